[rtl/mss_pkg.sv]
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the stepper pulse sequencer.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int MOTORS_DEF     = 3;
  localparam int COUNT_BITS_DEF = 16;
  localparam int MAX_MOTORS     = 3;

  localparam int CMD_W   = 2;
  localparam int SEL_W   = 2;
  localparam int STEPS_W = 17;
  localparam int MAG_W   = 17;
  localparam int DELAY_W = 16;
  localparam int PINS_W  = 8;
  localparam int POS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3;

  localparam logic [MAG_W-1:0]  RUN_PULSES = MAG_W'(10000);
  localparam logic [PINS_W-1:0] ENABLE_BIT = 8'h80;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_RUN  = 2'd2,
    CMD_STOP = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_COUNT  = 5'b00010,
    PH_DIRSET = 5'b00100,
    PH_STEP1  = 5'b01000,
    PH_STEP2  = 5'b10000
  } phase_t;

  typedef logic [POS_W-1:0] pos_t;

  // reset pin positions, per motor
  localparam pos_t DIR_POS_RST  [MAX_MOTORS] = '{3'd5, 3'd1, 3'd3};
  localparam pos_t STEP_POS_RST [MAX_MOTORS] = '{3'd6, 3'd2, 3'd4};

  // per-motor control for one accepted beat
  typedef struct packed {
    logic               tick;
    logic               load;
    logic               stop;
    logic               forward;
    logic [MAG_W-1:0]   pulses;
    logic [DELAY_W-1:0] delay;
  } motor_ctl_t;

  // per-motor status for the current beat
  typedef struct packed {
    logic              busy;       // not idle before the tick
    logic              busy_nxt;   // not idle after the tick
    logic [PINS_W-1:0] pins;
  } motor_sts_t;

endpackage

[rtl/mss_if.sv]
// ----------------------------------------------------------------------------
// mss_in_if / mss_out_if
// Valid/ready channels for command beats and pin result beats.
// ----------------------------------------------------------------------------
interface mss_in_if import mss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [SEL_W-1:0]          motor_sel;
  logic signed [STEPS_W-1:0] signed_steps;
  logic                      run_forward;
  logic [DELAY_W-1:0]        delay_ticks;

  modport source (output valid, command, motor_sel, signed_steps, run_forward,
                  delay_ticks, input ready);
  modport sink   (input valid, command, motor_sel, signed_steps, run_forward,
                  delay_ticks, output ready);
endinterface

interface mss_out_if import mss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PINS_W-1:0]     pin_byte;
  logic                  pins_changed;
  logic [MAX_MOTORS-1:0] active_mask;

  modport source (output valid, pin_byte, pins_changed, active_mask, input ready);
  modport sink   (input valid, pin_byte, pins_changed, active_mask, output ready);
endinterface

[rtl/multi_stepper_pulse_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// multi_stepper_pulse_sequencer_unit
// Step/dir pulse sequencer for up to three motors sharing one pin byte.
// ----------------------------------------------------------------------------
// channel  | dir | beat contents
// in_ch    | in  | command, motor_sel, signed_steps, run_forward, delay_ticks
// out_ch   | out | pin_byte, pins_changed, active_mask (one per tick beat)
// cfg_*    | in  | pin position writes, index 0..5
//
// One beat per cycle while in_ch.ready is high: each motor's phase update is a
// single short step between the accepted beat and the result register.
// Move, run and stop beats update state and produce no result.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
// Reset is synchronous; all motors idle, positions at defaults.
// ----------------------------------------------------------------------------
module multi_stepper_pulse_sequencer_unit import mss_pkg::*; #(
  parameter int MOTORS     = MOTORS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mss_in_if.sink                in_ch,
  mss_out_if.source             out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  pos_t              dir_pos_r  [MOTORS];
  pos_t              step_pos_r [MOTORS];
  motor_ctl_t        ctl        [MOTORS];
  motor_sts_t        sts        [MOTORS];

  logic              in_fire;
  logic              tick_fire;
  logic              neg;
  logic [MAG_W:0]    mag_full;
  logic [MAG_W-1:0]  mag;
  logic              move_fwd;
  logic              any_busy;
  logic [PINS_W-1:0] pins;
  logic [MAX_MOTORS-1:0] active;

  logic                  out_valid_r;
  logic [PINS_W-1:0]     pin_byte_r;
  logic                  changed_r;
  logic [MAX_MOTORS-1:0] active_r;
  logic [PINS_W-1:0]     prev_pins_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign tick_fire   = in_fire && (cmd_t'(in_ch.command) == CMD_TICK);

  // magnitude of the 17-bit two's complement step count
  assign neg      = in_ch.signed_steps[STEPS_W-1];
  assign mag_full = neg ? ((MAG_W+1)'(1) << MAG_W) - {1'b0, in_ch.signed_steps}
                        : {1'b0, in_ch.signed_steps};
  assign mag      = mag_full[MAG_W-1:0];
  assign move_fwd = !neg && (in_ch.signed_steps != '0);

  for (genvar m = 0; m < MOTORS; m++) begin : g_motor
    logic sel_hit;
    assign sel_hit = in_fire && (in_ch.motor_sel == SEL_W'(m));

    always_comb begin
      ctl[m].tick    = tick_fire;
      ctl[m].load    = sel_hit && ((cmd_t'(in_ch.command) == CMD_MOVE) ||
                                   (cmd_t'(in_ch.command) == CMD_RUN));
      ctl[m].stop    = sel_hit && (cmd_t'(in_ch.command) == CMD_STOP);
      ctl[m].forward = (cmd_t'(in_ch.command) == CMD_RUN) ? in_ch.run_forward : move_fwd;
      ctl[m].pulses  = (cmd_t'(in_ch.command) == CMD_RUN) ? RUN_PULSES : mag;
      ctl[m].delay   = in_ch.delay_ticks;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dir_pos_r[m]  <= DIR_POS_RST[m];
        step_pos_r[m] <= STEP_POS_RST[m];
      end else if (cfg_wr_en) begin
        if (cfg_index == CFG_IDX_W'(2 * m))     dir_pos_r[m]  <= cfg_wdata;
        if (cfg_index == CFG_IDX_W'(2 * m + 1)) step_pos_r[m] <= cfg_wdata;
      end
    end

    mss_motor #(
      .COUNT_BITS (COUNT_BITS)
    ) u_motor (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[m]),
      .dir_pos  (dir_pos_r[m]),
      .step_pos (step_pos_r[m]),
      .sts      (sts[m])
    );
  end

  always_comb begin
    any_busy = 1'b0;
    pins     = '0;
    active   = '0;
    for (int m = 0; m < MOTORS; m++) begin
      any_busy  = any_busy | sts[m].busy;
      pins      = pins | sts[m].pins;
      active[m] = sts[m].busy_nxt;
    end
    if (!any_busy) pins = pins | ENABLE_BIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_pins_r <= '0;
    end else if (tick_fire) begin
      out_valid_r <= 1'b1;
      prev_pins_r <= pins;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      pin_byte_r <= pins;
      changed_r  <= (pins != prev_pins_r);
      active_r   <= active;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pin_byte     = pin_byte_r;
  assign out_ch.pins_changed = changed_r;
  assign out_ch.active_mask  = active_r;

endmodule

[rtl/mss_motor.sv]
// ----------------------------------------------------------------------------
// mss_motor
// One motor's phase sequencer: countdown, dir setup, step high, step low.
// ----------------------------------------------------------------------------
module mss_motor import mss_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  motor_ctl_t ctl,
  input  pos_t       dir_pos,
  input  pos_t       step_pos,
  output motor_sts_t sts
);

  localparam int SW = (COUNT_BITS > MAG_W) ? COUNT_BITS : MAG_W;
  localparam logic [SW-1:0] CMAX = SW'((64'd1 << COUNT_BITS) - 64'd1);

  phase_t                phase_r, phase_nxt;
  logic                  fwd_r;
  logic [COUNT_BITS-1:0] pulses_r, pulses_nxt;
  logic [COUNT_BITS-1:0] interval_r;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [SW-1:0]         mag_ext, dly_ext;
  logic [COUNT_BITS-1:0] mag_sat, dly_sat;
  logic [PINS_W-1:0]     dbit, sbit, pins;

  assign mag_ext = SW'(ctl.pulses);
  assign dly_ext = SW'(ctl.delay);
  assign mag_sat = (mag_ext > CMAX) ? CMAX[COUNT_BITS-1:0] : mag_ext[COUNT_BITS-1:0];
  assign dly_sat = (dly_ext > CMAX) ? CMAX[COUNT_BITS-1:0] : dly_ext[COUNT_BITS-1:0];

  assign dbit = PINS_W'(1) << dir_pos;
  assign sbit = PINS_W'(1) << step_pos;

  always_comb begin
    phase_nxt  = phase_r;
    pulses_nxt = pulses_r;
    count_nxt  = count_r;
    pins       = '0;
    unique case (phase_r)
      PH_COUNT: begin
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end else begin
          count_nxt = interval_r;
          phase_nxt = PH_DIRSET;
          if (fwd_r) pins = dbit;
        end
      end
      PH_DIRSET: begin
        pins      = (fwd_r ? dbit : '0) | sbit;
        phase_nxt = PH_STEP1;
      end
      PH_STEP1: begin
        pins      = sbit;
        phase_nxt = PH_STEP2;
      end
      PH_STEP2: begin
        if (pulses_r != '0) pulses_nxt = pulses_r - 1'b1;
        phase_nxt = (pulses_nxt != '0) ? PH_COUNT : PH_IDLE;
      end
      PH_IDLE: phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  assign sts.busy     = (phase_r != PH_IDLE);
  assign sts.busy_nxt = (phase_nxt != PH_IDLE);
  assign sts.pins     = pins;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (ctl.load) begin
      phase_r <= (mag_sat != '0) ? PH_COUNT : PH_IDLE;
    end else if (ctl.stop) begin
      phase_r <= PH_IDLE;
    end else if (ctl.tick) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      fwd_r      <= ctl.forward;
      pulses_r   <= mag_sat;
      interval_r <= dly_sat;
      count_r    <= COUNT_BITS'(1);
    end else if (ctl.tick) begin
      pulses_r <= pulses_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
